// ----- design/flashlight_mode_controller_assert.svh -----
// ---------------------------------------------------------------------------
// flashlight mode controller assertion macros
// concurrent assertion wrappers used by the checker file
// ---------------------------------------------------------------------------
`ifndef FLASHLIGHT_MODE_CONTROLLER_ASSERT_SVH
`define FLASHLIGHT_MODE_CONTROLLER_ASSERT_SVH

// checked only while out of reset
`define FLM_ASSERT_ON(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked on every edge, reset included
`define FLM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- design/flm_pkg.sv -----
// ---------------------------------------------------------------------------
// flm_pkg
// types, codes and constants of the flashlight mode controller
// ---------------------------------------------------------------------------
package flm_pkg;

    localparam int TEMP_W  = 10;
    localparam int TICK_W  = 8;
    localparam int LEVEL_W = 11;
    localparam int MODE_W  = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_OVERTEMP_LIMIT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IDLE_OFF_TICKS   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TICKS       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BLINK_PERIOD     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BLINK_DARK_AFTER = 3'd4;

    // register reset values
    localparam logic [TEMP_W-1:0] RST_OVERTEMP_LIMIT   = 10'd340;
    localparam logic [TICK_W-1:0] RST_IDLE_OFF_TICKS   = 8'd62;
    localparam logic [TICK_W-1:0] RST_HOLD_TICKS       = 8'd37;
    localparam logic [TICK_W-1:0] RST_BLINK_PERIOD     = 8'd24;
    localparam logic [TICK_W-1:0] RST_BLINK_DARK_AFTER = 8'd8;

    localparam logic [TICK_W-1:0] TICK_MAX = 8'd255;

    // modes
    localparam logic [MODE_W-1:0] MODE_LAMP_OFF     = 4'd0;
    localparam logic [MODE_W-1:0] MODE_L1           = 4'd1;
    localparam logic [MODE_W-1:0] MODE_L2           = 4'd2;
    localparam logic [MODE_W-1:0] MODE_L3           = 4'd3;
    localparam logic [MODE_W-1:0] MODE_L4           = 4'd4;
    localparam logic [MODE_W-1:0] MODE_L5           = 4'd5;
    localparam logic [MODE_W-1:0] MODE_END_CYCLE    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_PERSIST      = 4'd7;
    localparam logic [MODE_W-1:0] MODE_PERSIST_LAST = 4'd8;
    localparam logic [MODE_W-1:0] MODE_HOLD         = 4'd9;

    // button codes
    localparam logic [1:0] BTN_NONE    = 2'd0;
    localparam logic [1:0] BTN_PRESS   = 2'd1;
    localparam logic [1:0] BTN_RELEASE = 2'd2;
    localparam logic [1:0] BTN_HELD    = 2'd3;
    localparam int         BTN_DOWN_BIT = 1;

    // charger status codes
    localparam logic [1:0] CHG_SHUTDOWN = 2'd0;
    localparam logic [1:0] CHG_CHARGING = 2'd1;
    localparam logic [1:0] CHG_FINISHED = 2'd2;
    localparam logic [1:0] CHG_KEEP     = 2'd3;

    // green indicator codes
    localparam logic [1:0] GREEN_OFF   = 2'd0;
    localparam logic [1:0] GREEN_ON    = 2'd1;
    localparam logic [1:0] GREEN_FLASH = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_DARK = 11'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 11'd2000;

    typedef struct packed {
        logic [TEMP_W-1:0] overtemp_limit;
        logic [TICK_W-1:0] idle_off_ticks;
        logic [TICK_W-1:0] hold_ticks;
        logic [TICK_W-1:0] blink_period;
        logic [TICK_W-1:0] blink_dark_after;
    } flm_cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [TICK_W-1:0]  up_ticks;
        logic [TICK_W-1:0]  down_ticks;
        logic [TICK_W-1:0]  blink_timer;
        logic [LEVEL_W-1:0] level;
        logic [1:0]         green;
    } flm_state_t;

    typedef struct packed {
        logic [1:0]        button_code;
        logic [TEMP_W-1:0] temperature;
        logic [1:0]        charger_status;
    } flm_tick_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode_now;
        logic [LEVEL_W-1:0] light_level;
        logic               light_update;
        logic               mode_changed;
        logic [1:0]         charge_led;
    } flm_result_t;

    localparam flm_state_t STATE_RESET = '{
        mode:        MODE_LAMP_OFF,
        up_ticks:    '0,
        down_ticks:  '0,
        blink_timer: '0,
        level:       LEVEL_DARK,
        green:       GREEN_OFF
    };

    function automatic logic [LEVEL_W-1:0] level_of(input logic [MODE_W-1:0] mode);
        logic [LEVEL_W-1:0] lvl;
        unique case (mode)
            MODE_LAMP_OFF: lvl = 11'd0;
            MODE_L1:       lvl = 11'd50;
            MODE_L2:       lvl = 11'd250;
            MODE_L3:       lvl = 11'd1000;
            MODE_L4:       lvl = 11'd1500;
            MODE_L5:       lvl = 11'd2000;
            default:       lvl = 11'd0;
        endcase
        return lvl;
    endfunction

    function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
        return (v < TICK_MAX) ? TICK_W'(v + 1'b1) : v;
    endfunction

endpackage

// ----- design/flm_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// flm_cfg_regs
// configuration register file with write-only access
// ---------------------------------------------------------------------------
module flm_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [flm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [flm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output flm_pkg::flm_cfg_t              cfg
);
    import flm_pkg::*;

    flm_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.overtemp_limit   <= RST_OVERTEMP_LIMIT;
            cfg_reg.idle_off_ticks   <= RST_IDLE_OFF_TICKS;
            cfg_reg.hold_ticks       <= RST_HOLD_TICKS;
            cfg_reg.blink_period     <= RST_BLINK_PERIOD;
            cfg_reg.blink_dark_after <= RST_BLINK_DARK_AFTER;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_OVERTEMP_LIMIT:   cfg_reg.overtemp_limit   <= cfg_wdata;
                REG_IDLE_OFF_TICKS:   cfg_reg.idle_off_ticks   <= cfg_wdata[TICK_W-1:0];
                REG_HOLD_TICKS:       cfg_reg.hold_ticks       <= cfg_wdata[TICK_W-1:0];
                REG_BLINK_PERIOD:     cfg_reg.blink_period     <= cfg_wdata[TICK_W-1:0];
                REG_BLINK_DARK_AFTER: cfg_reg.blink_dark_after <= cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/flm_tick_logic.sv -----
// ---------------------------------------------------------------------------
// flm_tick_logic
// one tick of counters, mode machine, blink and charge indicator
// ---------------------------------------------------------------------------
module flm_tick_logic (
    input  flm_pkg::flm_cfg_t    cfg,
    input  flm_pkg::flm_state_t  state,
    input  flm_pkg::flm_tick_t   tick,
    output flm_pkg::flm_state_t  state_next,
    output flm_pkg::flm_result_t result
);
    import flm_pkg::*;

    logic [TICK_W-1:0] up_n;
    logic [TICK_W-1:0] down_n;
    logic [TICK_W-1:0] blink_n;
    logic [MODE_W-1:0] req;
    logic [MODE_W-1:0] mode_n;
    logic [LEVEL_W-1:0] level_n;
    logic [1:0]        green_n;
    logic              changed;
    logic              update;
    logic [MODE_W-1:0] inc;

    always_comb begin
        // counters
        if (tick.button_code[BTN_DOWN_BIT]) begin
            down_n = sat_inc(state.down_ticks);
            up_n   = '0;
        end else begin
            up_n   = sat_inc(state.up_ticks);
            down_n = '0;
        end
        blink_n = sat_inc(state.blink_timer);

        // press, hold, release, overtemperature
        req = state.mode;
        inc = MODE_W'(state.mode + 1'b1);
        if (tick.button_code == BTN_PRESS) begin
            if (state.mode != MODE_LAMP_OFF && up_n >= cfg.idle_off_ticks) begin
                req = MODE_LAMP_OFF;
            end else if (state.mode < MODE_END_CYCLE) begin
                req = (inc == MODE_END_CYCLE) ? MODE_LAMP_OFF : inc;
            end else begin
                req = MODE_LAMP_OFF;
            end
        end
        if (down_n >= cfg.hold_ticks) begin
            if (state.mode == MODE_L1) begin
                req = MODE_HOLD;
            end else if (state.mode == MODE_L2) begin
                req = MODE_PERSIST;
            end
        end
        if (tick.button_code == BTN_RELEASE && state.mode > MODE_PERSIST_LAST) begin
            req = MODE_LAMP_OFF;
        end
        if (tick.temperature >= cfg.overtemp_limit) begin
            if (state.mode > MODE_L2) begin
                req = MODE_L2;
            end else if (req > MODE_L2) begin
                req = MODE_LAMP_OFF;
            end
        end

        // mode change with level command
        mode_n  = req;
        level_n = state.level;
        changed = (req != state.mode);
        update  = changed;
        if (changed) begin
            if (req < MODE_END_CYCLE) begin
                level_n = level_of(req);
            end else begin
                blink_n = '0;
                level_n = LEVEL_FULL;
            end
        end

        // blink
        if (mode_n == MODE_PERSIST || mode_n == MODE_HOLD) begin
            if (blink_n >= cfg.blink_period) begin
                level_n = LEVEL_FULL;
                blink_n = '0;
                update  = 1'b1;
            end else if (blink_n >= cfg.blink_dark_after) begin
                level_n = LEVEL_DARK;
                update  = 1'b1;
            end
        end

        // charge indicator
        unique case (tick.charger_status)
            CHG_SHUTDOWN: green_n = GREEN_OFF;
            CHG_CHARGING: green_n = GREEN_FLASH;
            CHG_FINISHED: green_n = GREEN_ON;
            default:      green_n = state.green;
        endcase

        state_next.mode        = mode_n;
        state_next.up_ticks    = up_n;
        state_next.down_ticks  = down_n;
        state_next.blink_timer = blink_n;
        state_next.level       = level_n;
        state_next.green       = green_n;

        result.mode_now     = mode_n;
        result.light_level  = level_n;
        result.light_update = update;
        result.mode_changed = changed;
        result.charge_led   = green_n;
    end

endmodule

// ----- design/flashlight_mode_controller.sv -----
// ---------------------------------------------------------------------------
// flashlight_mode_controller
// tick-driven mode controller for a handheld light
// ---------------------------------------------------------------------------
//  channel  direction  ports                                  word
//  s_       in         button_code temperature charger_status one tick
//  m_       out        mode_now light_level light_update      one result
//                      mode_changed charge_led
//  cfg_     in         wr_en addr wdata                       one register
//
//  one tick per cycle sustained while results are taken; a tick goes into
//  the input register, then through the tick logic into the result register
//  the tick logic is combinational; the controller state updates on advance
//  reset clears state, counters and valids and loads register defaults
//  a stalled result holds; s_ready stays high while the result register
//  can take the pending tick
// ---------------------------------------------------------------------------
module flashlight_mode_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_button_code,
    input  logic [flm_pkg::TEMP_W-1:0]        s_temperature,
    input  logic [1:0]                        s_charger_status,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [flm_pkg::MODE_W-1:0]        m_mode_now,
    output logic [flm_pkg::LEVEL_W-1:0]       m_light_level,
    output logic                              m_light_update,
    output logic                              m_mode_changed,
    output logic [1:0]                        m_charge_led,
    input  logic                              cfg_wr_en,
    input  logic [flm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [flm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import flm_pkg::*;

    flm_cfg_t    cfg;
    flm_state_t  state_reg;
    flm_state_t  state_next;
    flm_tick_t   tick_reg;
    flm_result_t result_next;
    flm_result_t result_reg;
    logic        tick_valid_reg;
    logic        m_valid_reg;
    logic        advance;

    flm_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    flm_tick_logic u_tick_logic (
        .cfg        (cfg),
        .state      (state_reg),
        .tick       (tick_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign advance = tick_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !tick_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            state_reg      <= STATE_RESET;
        end else begin
            if (s_ready) begin
                tick_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            tick_reg.button_code    <= s_button_code;
            tick_reg.temperature    <= s_temperature;
            tick_reg.charger_status <= s_charger_status;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_mode_now     = result_reg.mode_now;
    assign m_light_level  = result_reg.light_level;
    assign m_light_update = result_reg.light_update;
    assign m_mode_changed = result_reg.mode_changed;
    assign m_charge_led   = result_reg.charge_led;

endmodule

// ----- design/flm_checker.sv -----
// ---------------------------------------------------------------------------
// flm_checker
// port-level checks of the flashlight mode controller, bound to the top
// ---------------------------------------------------------------------------
`include "flashlight_mode_controller_assert.svh"

module flm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [flm_pkg::MODE_W-1:0]     m_mode_now,
    input logic [flm_pkg::LEVEL_W-1:0]    m_light_level,
    input logic                           m_light_update,
    input logic                           m_mode_changed,
    input logic [1:0]                     m_charge_led
);
    import flm_pkg::*;

    logic [MODE_W+LEVEL_W+3:0] out_word;
    logic                      blinky_entry;
    logic                      blinky_lit;

    assign out_word     = {m_mode_now, m_light_level, m_light_update, m_mode_changed,
                           m_charge_led};
    assign blinky_entry = m_valid && m_mode_changed &&
                          (m_mode_now == MODE_PERSIST || m_mode_now == MODE_HOLD);
    assign blinky_lit   = m_light_update &&
                          (m_light_level == LEVEL_FULL || m_light_level == LEVEL_DARK);

    // no result word right after reset
    `FLM_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid, "result valid after reset")

    // stalled result word holds
    `FLM_ASSERT_ON(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(out_word), "stalled")

    // empty result register never blocks input
    `FLM_ASSERT_ON(a_ready_when_empty, !m_valid |-> s_ready, "input blocked with empty output")

    // entering a blinky mode commands the light full or dark
    `FLM_ASSERT_ON(a_blinky_entry, blinky_entry |-> blinky_lit, "blinky entry not commanded")

endmodule

bind flashlight_mode_controller flm_checker u_flm_checker (.*);

// ----- verif/flashlight_mode_controller_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flashlight_mode_controller_tb
// ticks run through the mode controller against a cycle-free predictor;
// a directed sequence walks the level cycle, idle-off, hold and persist
// blinky, release and overtemperature, then register settings from the
// defaults to both extremes carry button gestures with random content
// under random valid and ready bursts
// ---------------------------------------------------------------------------
module flashlight_mode_controller_tb;
    import flm_pkg::*;

    logic                  aclk;
    logic                  aresetn          = 1'b0;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_button_code    = '0;
    logic [TEMP_W-1:0]     s_temperature    = '0;
    logic [1:0]            s_charger_status = '0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic [MODE_W-1:0]     m_mode_now;
    logic [LEVEL_W-1:0]    m_light_level;
    logic                  m_light_update;
    logic                  m_mode_changed;
    logic [1:0]            m_charge_led;
    logic                  cfg_wr_en        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr         = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata        = '0;

    flashlight_mode_controller dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_button_code    (s_button_code),
        .s_temperature    (s_temperature),
        .s_charger_status (s_charger_status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mode_now       (m_mode_now),
        .m_light_level    (m_light_level),
        .m_light_update   (m_light_update),
        .m_mode_changed   (m_mode_changed),
        .m_charge_led     (m_charge_led),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    flm_cfg_t    lamp_cfg;
    flm_state_t  lamp_st;
    flm_tick_t   tick_backlog[$];
    flm_result_t lamp_expect[$];

    logic s_taken    = 1'b0;
    bit   idle_on    = 1'b1;
    int   errors     = 0;
    int   ticks_seen = 0;
    int   blinky_hits = 0;
    int   settings   = 0;
    int   phase_ticks;

    function automatic flm_result_t advance_lamp(input flm_tick_t tk);
        flm_result_t       r;
        logic [MODE_W-1:0] nxt;
        logic              upd;
        logic              chg;
        nxt = lamp_st.mode;
        upd = 1'b0;
        chg = 1'b0;
        if (tk.button_code[BTN_DOWN_BIT]) begin
            if (lamp_st.down_ticks != TICK_MAX) lamp_st.down_ticks = lamp_st.down_ticks + 1'b1;
            lamp_st.up_ticks = '0;
        end else begin
            if (lamp_st.up_ticks != TICK_MAX) lamp_st.up_ticks = lamp_st.up_ticks + 1'b1;
            lamp_st.down_ticks = '0;
        end
        if (lamp_st.blink_timer != TICK_MAX) lamp_st.blink_timer = lamp_st.blink_timer + 1'b1;

        if (tk.button_code == BTN_PRESS) begin
            if (lamp_st.mode != MODE_LAMP_OFF && lamp_st.up_ticks >= lamp_cfg.idle_off_ticks) begin
                nxt = MODE_LAMP_OFF;
            end else if (lamp_st.mode < MODE_END_CYCLE) begin
                nxt = lamp_st.mode + 1'b1;
                if (nxt == MODE_END_CYCLE) nxt = MODE_LAMP_OFF;
            end else begin
                nxt = MODE_LAMP_OFF;
            end
        end
        if (lamp_st.down_ticks >= lamp_cfg.hold_ticks) begin
            if (lamp_st.mode == MODE_L1) nxt = MODE_HOLD;
            else if (lamp_st.mode == MODE_L2) nxt = MODE_PERSIST;
        end
        if (tk.button_code == BTN_RELEASE && lamp_st.mode > MODE_PERSIST_LAST) nxt = MODE_LAMP_OFF;
        if (tk.temperature >= lamp_cfg.overtemp_limit) begin
            if (lamp_st.mode > MODE_L2) nxt = MODE_L2;
            else if (nxt > MODE_L2) nxt = MODE_LAMP_OFF;
        end

        if (nxt != lamp_st.mode) begin
            chg = 1'b1;
            upd = 1'b1;
            lamp_st.mode = nxt;
            case (nxt)
                MODE_LAMP_OFF: lamp_st.level = 11'd0;
                MODE_L1:  lamp_st.level = 11'd50;
                MODE_L2:  lamp_st.level = 11'd250;
                MODE_L3:  lamp_st.level = 11'd1000;
                MODE_L4:  lamp_st.level = 11'd1500;
                MODE_L5:  lamp_st.level = 11'd2000;
                default: begin
                    lamp_st.blink_timer = '0;
                    lamp_st.level = LEVEL_FULL;
                end
            endcase
        end

        if (lamp_st.mode == MODE_PERSIST || lamp_st.mode == MODE_HOLD) begin
            if (lamp_st.blink_timer >= lamp_cfg.blink_period) begin
                lamp_st.level = LEVEL_FULL;
                lamp_st.blink_timer = '0;
                upd = 1'b1;
            end else if (lamp_st.blink_timer >= lamp_cfg.blink_dark_after) begin
                lamp_st.level = LEVEL_DARK;
                upd = 1'b1;
            end
        end

        case (tk.charger_status)
            CHG_SHUTDOWN: lamp_st.green = GREEN_OFF;
            CHG_CHARGING: lamp_st.green = GREEN_FLASH;
            CHG_FINISHED: lamp_st.green = GREEN_ON;
            default: ;
        endcase

        r.mode_now     = lamp_st.mode;
        r.light_level  = lamp_st.level;
        r.light_update = upd;
        r.mode_changed = chg;
        r.charge_led   = lamp_st.green;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // input acceptance feeds the predictor, result acceptance is checked
    always @(posedge aclk) begin : monitor
        flm_tick_t   tk;
        flm_result_t want;
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                tk.button_code    = s_button_code;
                tk.temperature    = s_temperature;
                tk.charger_status = s_charger_status;
                lamp_expect.push_back(advance_lamp(tk));
            end
            if (m_valid && m_ready) begin
                if (lamp_expect.size() == 0) begin
                    $error("result word with no tick waiting");
                    errors++;
                end else begin
                    want = lamp_expect.pop_front();
                    ticks_seen++;
                    if (want.mode_changed &&
                        (want.mode_now == MODE_HOLD || want.mode_now == MODE_PERSIST))
                        blinky_hits++;
                    check_field("mode_now", want.mode_now, m_mode_now);
                    check_field("light_level", want.light_level, m_light_level);
                    check_field("light_update", want.light_update, m_light_update);
                    check_field("mode_changed", want.mode_changed, m_mode_changed);
                    check_field("charge_led", want.charge_led, m_charge_led);
                end
            end
        end
    end

    // source and sink, both with random idle bursts
    always @(negedge aclk) begin : driver
        static int s_gap = 0;
        static int r_gap = 0;
        flm_tick_t tk;
        if (aresetn) begin
            if (!s_valid || s_taken) begin
                if (s_gap != 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (idle_on && tick_backlog.size() != 0 && $urandom_range(0, 5) == 0) begin
                    s_gap = $urandom_range(0, 16);
                    s_valid <= 1'b0;
                end else if (tick_backlog.size() != 0) begin
                    tk = tick_backlog.pop_front();
                    s_valid          <= 1'b1;
                    s_button_code    <= tk.button_code;
                    s_temperature    <= tk.temperature;
                    s_charger_status <= tk.charger_status;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (r_gap != 0) begin
                r_gap--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                r_gap = $urandom_range(0, 16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_tick(input logic [1:0] btn, input logic [TEMP_W-1:0] temp,
                             input logic [1:0] chg);
        flm_tick_t tk;
        tk.button_code    = btn;
        tk.temperature    = temp;
        tk.charger_status = chg;
        tick_backlog.push_back(tk);
        phase_ticks++;
    endtask

    task automatic program_reg(input logic [CFG_ADDR_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_OVERTEMP_LIMIT:   lamp_cfg.overtemp_limit   = val;
            REG_IDLE_OFF_TICKS:   lamp_cfg.idle_off_ticks   = val[TICK_W-1:0];
            REG_HOLD_TICKS:       lamp_cfg.hold_ticks       = val[TICK_W-1:0];
            REG_BLINK_PERIOD:     lamp_cfg.blink_period     = val[TICK_W-1:0];
            REG_BLINK_DARK_AFTER: lamp_cfg.blink_dark_after = val[TICK_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_all(input int ot, input int idle, input int hold,
                               input int per, input int dark);
        wait (tick_backlog.size() == 0 && !s_valid && lamp_expect.size() == 0);
        repeat (4) @(posedge aclk);
        program_reg(REG_OVERTEMP_LIMIT, CFG_DATA_W'(ot));
        program_reg(REG_IDLE_OFF_TICKS, CFG_DATA_W'(idle));
        program_reg(REG_HOLD_TICKS, CFG_DATA_W'(hold));
        program_reg(REG_BLINK_PERIOD, CFG_DATA_W'(per));
        program_reg(REG_BLINK_DARK_AFTER, CFG_DATA_W'(dark));
        settings++;
        phase_ticks = 0;
    endtask

    function automatic logic [TEMP_W-1:0] pick_temp();
        int lim;
        lim = lamp_cfg.overtemp_limit;
        if (lim == 0 || $urandom_range(0, 99) < 12) return TEMP_W'($urandom_range(lim, 1023));
        return TEMP_W'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [1:0] pick_charger();
        if ($urandom_range(0, 9) < 6) return CHG_KEEP;
        return 2'($urandom_range(0, 3));
    endfunction

    function automatic int near(input int centre);
        int k;
        k = centre + int'($urandom_range(0, 6)) - 2;
        return (k < 0) ? 0 : k;
    endfunction

    // press, hold down, release, rest; some broken or pure noise
    task automatic queue_gesture();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 6))
                push_tick(2'($urandom_range(0, 3)), pick_temp(), pick_charger());
            return;
        end
        push_tick(BTN_PRESS, pick_temp(), pick_charger());
        n = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : near(lamp_cfg.hold_ticks);
        repeat (n) push_tick(BTN_HELD, pick_temp(), pick_charger());
        if ($urandom_range(0, 99) < 85) push_tick(BTN_RELEASE, pick_temp(), pick_charger());
        kind = $urandom_range(0, 9);
        if (kind < 5) n = $urandom_range(0, 4);
        else if (kind < 8) n = near(lamp_cfg.idle_off_ticks);
        else n = $urandom_range(0, 20);
        repeat (n) push_tick(BTN_NONE, pick_temp(), pick_charger());
    endtask

    initial begin : stimulus
        int ph;
        int ot;
        int idle;
        int hold;
        int per;
        int dark;
        lamp_st  = STATE_RESET;
        lamp_cfg = '{overtemp_limit: RST_OVERTEMP_LIMIT, idle_off_ticks: RST_IDLE_OFF_TICKS,
                     hold_ticks: RST_HOLD_TICKS, blink_period: RST_BLINK_PERIOD,
                     blink_dark_after: RST_BLINK_DARK_AFTER};
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed walk through the mode machine
        program_all(600, 8, 2, 3, 1);
        push_tick(BTN_NONE, 10'd0, CHG_SHUTDOWN);
        push_tick(BTN_PRESS, 10'd0, CHG_KEEP);
        push_tick(BTN_PRESS, 10'd599, CHG_CHARGING);
        push_tick(BTN_PRESS, 10'd1, CHG_FINISHED);
        push_tick(BTN_PRESS, 10'd2, CHG_KEEP);
        push_tick(BTN_PRESS, 10'd3, CHG_KEEP);
        push_tick(BTN_PRESS, 10'd4, CHG_KEEP);       // level 5 wraps to off
        push_tick(BTN_PRESS, 10'd5, CHG_KEEP);
        push_tick(BTN_PRESS, 10'd6, CHG_SHUTDOWN);   // idle too long, goes off
        push_tick(BTN_HELD, 10'd7, CHG_KEEP);
        push_tick(BTN_HELD, 10'd8, CHG_KEEP);        // hold while off
        push_tick(BTN_HELD, 10'd9, CHG_KEEP);
        push_tick(BTN_PRESS, 10'd10, CHG_KEEP);
        push_tick(BTN_HELD, 10'd11, CHG_KEEP);
        push_tick(BTN_HELD, 10'd12, CHG_CHARGING);   // hold blinky
        push_tick(BTN_HELD, 10'd13, CHG_KEEP);
        push_tick(BTN_HELD, 10'd14, CHG_KEEP);
        push_tick(BTN_HELD, 10'd15, CHG_KEEP);       // relight
        push_tick(BTN_RELEASE, 10'd16, CHG_KEEP);    // release ends hold blinky
        push_tick(BTN_PRESS, 10'd17, CHG_KEEP);
        push_tick(BTN_PRESS, 10'd18, CHG_KEEP);
        push_tick(BTN_HELD, 10'd19, CHG_KEEP);
        push_tick(BTN_HELD, 10'd20, CHG_FINISHED);   // persist blinky
        push_tick(BTN_RELEASE, 10'd21, CHG_KEEP);
        push_tick(BTN_NONE, 10'd1023, CHG_KEEP);     // overtemp drops to level 2
        push_tick(BTN_PRESS, 10'd1023, CHG_KEEP);    // capped request goes off

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    ot = RST_OVERTEMP_LIMIT; idle = RST_IDLE_OFF_TICKS; hold = RST_HOLD_TICKS;
                    per = RST_BLINK_PERIOD; dark = RST_BLINK_DARK_AFTER;
                end
                1: begin
                    ot = 0; idle = 0; hold = 0; per = 0; dark = 0;
                end
                2: begin
                    ot = 1023; idle = 255; hold = 255; per = 255; dark = 255;
                end
                default: begin
                    ot   = ($urandom_range(0, 4) == 0) ? 1023 : $urandom_range(200, 1000);
                    idle = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 40);
                    hold = $urandom_range(0, 30);
                    per  = $urandom_range(0, 40);
                    dark = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 30);
                end
            endcase
            program_all(ot, idle, hold, per, dark);
            idle_on = (ph != 5 && ph != 7);
            while (phase_ticks < 135) queue_gesture();
        end

        wait (tick_backlog.size() == 0 && !s_valid && lamp_expect.size() == 0);
        repeat (10) @(posedge aclk);
        $display("checked %0d result words over %0d register settings", ticks_seen, settings);
        $display("blinky modes entered %0d times", blinky_hits);
        if (errors == 0) begin
            $display("PASS flashlight_mode_controller");
        end else begin
            $display("FAIL flashlight_mode_controller");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAIL flashlight_mode_controller");
        $finish;
    end

endmodule
